// ===== design/hkt_pkg.sv =====
// ----------------------------------------------------------------------------
// hkt_pkg
// Shared constants, types and the scan code to ASCII map of the held-key
// tracker.
// ----------------------------------------------------------------------------
package hkt_pkg;

   localparam int LIST_DEPTH  = 6;
   localparam int SHOWN_SLOTS = 6;
   localparam int CNT_W       = $clog2(LIST_DEPTH + 1);

   localparam logic [7:0] BREAK_PREFIX = 8'hF0;
   localparam logic [7:0] NO_KEY       = 8'h00;

   typedef logic [7:0] key_type;
   typedef logic [CNT_W-1:0] count_type;

   // Scan code set 2 to ASCII; NO_KEY for unmapped codes.
   function automatic key_type key_of(input logic [7:0] code);
      key_type k;
      case (code)
         8'h1C: k = "a";
         8'h32: k = "b";
         8'h21: k = "c";
         8'h23: k = "d";
         8'h24: k = "e";
         8'h2B: k = "f";
         8'h34: k = "g";
         8'h33: k = "h";
         8'h43: k = "i";
         8'h3B: k = "j";
         8'h42: k = "k";
         8'h4B: k = "l";
         8'h3A: k = "m";
         8'h31: k = "n";
         8'h44: k = "o";
         8'h4D: k = "p";
         8'h15: k = "q";
         8'h2D: k = "r";
         8'h1B: k = "s";
         8'h2C: k = "t";
         8'h3C: k = "u";
         8'h2A: k = "v";
         8'h1D: k = "w";
         8'h22: k = "x";
         8'h35: k = "y";
         8'h1A: k = "z";
         8'h45: k = "0";
         8'h16: k = "1";
         8'h1E: k = "2";
         8'h26: k = "3";
         8'h25: k = "4";
         8'h2E: k = "5";
         8'h36: k = "6";
         8'h3D: k = "7";
         8'h3E: k = "8";
         8'h46: k = "9";
         8'h5D: k = "#";
         default: k = NO_KEY;
      endcase
      return k;
   endfunction

endpackage

// ===== design/hkt_req_if.sv =====
// ----------------------------------------------------------------------------
// hkt_req_if
// Scan code channel: one received PS/2 byte per item.
// ----------------------------------------------------------------------------
interface hkt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] scan_code;

   modport source (output valid, output scan_code, input ready);
   modport sink   (input valid, input scan_code, output ready);
endinterface

// ===== design/hkt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// hkt_rsp_if
// Result channel: snapshot of the held-key list per item.
// ----------------------------------------------------------------------------
interface hkt_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] held_key0;
   logic [7:0] held_key1;
   logic [7:0] held_key2;
   logic [7:0] held_key3;
   logic [7:0] held_key4;
   logic [7:0] held_key5;
   logic [2:0] held_count;

   modport source (output valid, output held_key0, output held_key1, output held_key2,
                   output held_key3, output held_key4, output held_key5,
                   output held_count, input ready);
   modport sink   (input valid, input held_key0, input held_key1, input held_key2,
                   input held_key3, input held_key4, input held_key5,
                   input held_count, output ready);
endinterface

// ===== design/ps2_held_key_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// ps2_held_key_tracker_unit
// Tracks PS/2 set 2 keys held down, in press order, from received bytes.
// ----------------------------------------------------------------------------
// An accepted byte is registered in the input stage, then its result in the result register.
// Throughput: 1 byte per cycle while the input stage does not stall; a break prefix byte gives no result.
// The input stage stalls only while a result waits and the byte needs a slot.
// Reset (synchronous): list empty, break flag clear, both stages empty.
module ps2_held_key_tracker_unit (
   input logic         clock,
   input logic         reset,
   hkt_req_if.sink     req_chan,
   hkt_rsp_if.source   rsp_chan
);

   localparam int DEPTH = hkt_pkg::LIST_DEPTH;
   localparam int CW    = hkt_pkg::CNT_W;

   logic                 s1_valid_ff, s1_valid_in;
   logic [7:0]           s1_code_ff;
   logic                 release_pending_ff, release_pending_in;
   hkt_pkg::key_type     list_ff [DEPTH];
   hkt_pkg::key_type     list_in [DEPTH];
   logic                 rsp_valid_ff, rsp_valid_in;
   hkt_pkg::key_type     rsp_key_ff [hkt_pkg::SHOWN_SLOTS];
   logic [2:0]           rsp_count_ff;

   logic                 is_break;
   logic                 s1_advance;
   hkt_pkg::key_type     key;
   hkt_pkg::count_type   n_held;
   hkt_pkg::count_type   n_next;
   hkt_pkg::count_type   pos;
   logic                 found;

   assign is_break   = (s1_code_ff == hkt_pkg::BREAK_PREFIX);
   assign s1_advance = s1_valid_ff && (is_break || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign key        = hkt_pkg::key_of(s1_code_ff);

   always_comb begin
      n_held = '0;
      found  = 1'b0;
      pos    = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (list_ff[i] != hkt_pkg::NO_KEY) begin
            n_held = n_held + 1'b1;
         end
         if (!found && list_ff[i] == key) begin
            found = 1'b1;
            pos   = CW'(i);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         list_in[i] = list_ff[i];
      end
      if (key != hkt_pkg::NO_KEY) begin
         if (release_pending_ff) begin
            if (found) begin
               for (int i = 0; i < DEPTH; i++) begin
                  if (CW'(i) >= pos) begin
                     list_in[i] = (i + 1 < DEPTH) ? list_ff[(i + 1) % DEPTH] : hkt_pkg::NO_KEY;
                  end
               end
            end
         end else if (!found && n_held < CW'(DEPTH)) begin
            for (int i = 0; i < DEPTH; i++) begin
               if (CW'(i) == n_held) begin
                  list_in[i] = key;
               end
            end
         end
      end
   end

   always_comb begin
      n_next = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (list_in[i] != hkt_pkg::NO_KEY) begin
            n_next = n_next + 1'b1;
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_chan.valid && req_chan.ready) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      release_pending_in = release_pending_ff;
      if (s1_advance) begin
         release_pending_in = is_break;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance && !is_break) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff        <= 1'b0;
         release_pending_ff <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         for (int i = 0; i < DEPTH; i++) begin
            list_ff[i] <= hkt_pkg::NO_KEY;
         end
      end else begin
         s1_valid_ff        <= s1_valid_in;
         release_pending_ff <= release_pending_in;
         rsp_valid_ff       <= rsp_valid_in;
         if (s1_advance && !is_break) begin
            for (int i = 0; i < DEPTH; i++) begin
               list_ff[i] <= list_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s1_code_ff <= req_chan.scan_code;
      end
      if (s1_advance && !is_break) begin
         for (int i = 0; i < hkt_pkg::SHOWN_SLOTS; i++) begin
            rsp_key_ff[i] <= (i < DEPTH) ? list_in[i % DEPTH] : hkt_pkg::NO_KEY;
         end
         rsp_count_ff <= (n_next > CW'(7)) ? 3'd7 : 3'(n_next);
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.held_key0  = rsp_key_ff[0];
   assign rsp_chan.held_key1  = rsp_key_ff[1];
   assign rsp_chan.held_key2  = rsp_key_ff[2];
   assign rsp_chan.held_key3  = rsp_key_ff[3];
   assign rsp_chan.held_key4  = rsp_key_ff[4];
   assign rsp_chan.held_key5  = rsp_key_ff[5];
   assign rsp_chan.held_count = rsp_count_ff;

`ifndef ASSERT_OFF
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      s1_advance && !is_break |=> rsp_valid_ff)
      else $error("mapped byte gave no result");

   a_break_sets_flag: assert property (@(posedge clock) disable iff (reset)
      s1_advance && is_break |=> release_pending_ff && !$rose(rsp_valid_ff))
      else $error("break prefix handled wrong");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      n_held <= CW'(DEPTH))
      else $error("held count beyond list depth");

   a_list_packed: assert property (@(posedge clock) disable iff (reset)
      list_ff[0] == hkt_pkg::NO_KEY |-> n_held == '0)
      else $error("held list not packed at front");
`endif

endmodule

// ===== verif/ps2_held_key_tracker_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_held_key_tracker_checker
// Watches the scan code and result channels of the held-key tracker. Keeps
// its own copy of the held-key list and the break flag, works out the list
// snapshot each accepted byte other than a break prefix should produce, and compares every accepted
// result, field by field, against the oldest snapshot still waiting.
// ----------------------------------------------------------------------------
module ps2_held_key_tracker_checker (
   input  logic clock,
   input  logic reset,
   hkt_req_if   req_mon,
   hkt_rsp_if   rsp_mon,
   output int   fail_count,
   output int   open_count
);

   localparam int NUM_MAPPED = 37;

   // Set 2 make codes, in the order of SET2_CHARS.
   localparam logic [7:0] SET2_CODES [NUM_MAPPED] = '{
      8'h1C, 8'h32, 8'h21, 8'h23, 8'h24, 8'h2B, 8'h34, 8'h33, 8'h43, 8'h3B,
      8'h42, 8'h4B, 8'h3A, 8'h31, 8'h44, 8'h4D, 8'h15, 8'h2D, 8'h1B, 8'h2C,
      8'h3C, 8'h2A, 8'h1D, 8'h22, 8'h35, 8'h1A,
      8'h45, 8'h16, 8'h1E, 8'h26, 8'h25, 8'h2E, 8'h36, 8'h3D, 8'h3E, 8'h46,
      8'h5D
   };
   localparam logic [8*NUM_MAPPED-1:0] SET2_CHARS =
      "abcdefghijklmnopqrstuvwxyz0123456789#";

   typedef struct packed {
      logic [hkt_pkg::SHOWN_SLOTS-1:0][7:0] keys;
      logic [2:0]                           count;
   } snapshot_type;

   hkt_pkg::key_type held [hkt_pkg::LIST_DEPTH];
   logic             break_seen;
   snapshot_type     snapshot_q [$];

   function automatic hkt_pkg::key_type ascii_of(input logic [7:0] code);
      for (int i = 0; i < NUM_MAPPED; i++)
         if (SET2_CODES[i] == code)
            return SET2_CHARS[8*(NUM_MAPPED-1-i) +: 8];
      return hkt_pkg::NO_KEY;
   endfunction

   function automatic int keys_held();
      int n;
      n = 0;
      for (int i = 0; i < hkt_pkg::LIST_DEPTH; i++)
         if (held[i] != hkt_pkg::NO_KEY)
            n++;
      return n;
   endfunction

   function automatic void track_code(input logic [7:0] code);
      hkt_pkg::key_type k;
      int               n;
      int               pos;
      logic             releasing;
      snapshot_type     snap;
      if (code == hkt_pkg::BREAK_PREFIX) begin
         break_seen = 1'b1;
         return;
      end
      releasing  = break_seen;
      break_seen = 1'b0;
      k   = ascii_of(code);
      n   = keys_held();
      pos = -1;
      for (int i = 0; i < n; i++)
         if (pos < 0 && held[i] == k)
            pos = i;
      if (k != hkt_pkg::NO_KEY) begin
         if (releasing) begin
            if (pos >= 0) begin
               for (int i = pos; i < hkt_pkg::LIST_DEPTH - 1; i++)
                  held[i] = held[i+1];
               held[hkt_pkg::LIST_DEPTH-1] = hkt_pkg::NO_KEY;
            end
         end else if (pos < 0 && n < hkt_pkg::LIST_DEPTH) begin
            held[n] = k;
         end
      end
      snap.keys = '0;
      for (int i = 0; i < hkt_pkg::SHOWN_SLOTS && i < hkt_pkg::LIST_DEPTH; i++)
         snap.keys[i] = held[i];
      n = keys_held();
      snap.count = (n > 7) ? 3'd7 : 3'(n);
      snapshot_q.push_back(snap);
   endfunction

   always @(posedge clock) begin
      snapshot_type                         want;
      logic [hkt_pkg::SHOWN_SLOTS-1:0][7:0] got;
      int                                   errs;
      errs = 0;
      if (reset) begin
         for (int i = 0; i < hkt_pkg::LIST_DEPTH; i++)
            held[i] = hkt_pkg::NO_KEY;
         break_seen = 1'b0;
         snapshot_q.delete();
         fail_count <= 0;
         open_count <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            track_code(req_mon.scan_code);
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.held_key5, rsp_mon.held_key4, rsp_mon.held_key3,
                   rsp_mon.held_key2, rsp_mon.held_key1, rsp_mon.held_key0};
            if (snapshot_q.size() == 0) begin
               $display("%0t: unexpected result, keys %h count %0d",
                        $time, got, rsp_mon.held_count);
               errs++;
            end else begin
               want = snapshot_q.pop_front();
               for (int i = 0; i < hkt_pkg::SHOWN_SLOTS; i++)
                  if (got[i] !== want.keys[i]) begin
                     $display("%0t: held_key%0d expected %h actual %h",
                              $time, i, want.keys[i], got[i]);
                     errs++;
                  end
               if (rsp_mon.held_count !== want.count) begin
                  $display("%0t: held_count expected %0d actual %0d",
                           $time, want.count, rsp_mon.held_count);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
         open_count <= snapshot_q.size();
      end
   end

endmodule

// ===== verif/ps2_held_key_tracker_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_held_key_tracker_unit_tb
// Drives scan code bytes into the held-key tracker: a directed run over
// duplicates, a full list, repeated break prefixes, unmapped codes and
// releases of absent and held keys, then random press/release traffic over
// shifting key pools mixed with noise. Sender bursts and receiver stalls are
// random, with one long receiver hold-off and drain pauses. The checker
// beside the block does the comparing.
// ----------------------------------------------------------------------------
module ps2_held_key_tracker_unit_tb;

   localparam int RANDOM_ITEMS = 1100;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_AT      = 500;
   localparam int HOLD_LEN     = 200;
   localparam int DRAIN_CYCLES = 10;

   typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_type;

   logic clock;
   logic reset;
   int   fail_count;
   int   open_count;
   int   items_sent  = 0;
   int   burst_left  = 0;
   int   cycle_count = 0;

   logic [7:0] key_codes [$];
   logic [7:0] code_q [$];

   hkt_req_if req_chan();
   hkt_rsp_if rsp_chan();

   ps2_held_key_tracker_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   ps2_held_key_tracker_checker held_key_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .fail_count (fail_count),
      .open_count (open_count)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send_code(input logic [7:0] code);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_chan.valid     <= 1'b1;
      req_chan.scan_code <= code;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      items_sent <= items_sent + 1;
   endtask

   task automatic wait_for_drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
   endtask

   // Receiver: random ready patterns, plus one long hold-off to back up the block.
   initial begin
      rx_mode_type mode;
      int          mode_left;
      int          hold_left;
      bit          hold_done;
      mode      = RX_STEADY;
      mode_left = 0;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && items_sent >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
         end
         if (mode_left == 0) begin
            mode      = rx_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 96);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            case (mode)
               RX_STEADY: rsp_chan.ready <= 1'b1;
               RX_COIN:   rsp_chan.ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_chan.ready <= ($urandom_range(0, 4) == 0);
               default:   rsp_chan.ready <= ($urandom_range(0, 4) != 0);
            endcase
         end
      end
   end

   initial begin
      int         pool_lo;
      int         pool_len;
      int         window_left;
      int         pick;
      int         half;
      logic [7:0] k;

      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.scan_code <= 8'h00;
      for (int c = 0; c < 256; c++)
         if (hkt_pkg::key_of(8'(c)) != hkt_pkg::NO_KEY)
            key_codes.push_back(8'(c));
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Press a, again a, release of absent b, fill to six, drop on full,
      // unmapped codes, double prefix, prefix before unmapped, then empty out.
      code_q = '{8'h1C, 8'h1C, hkt_pkg::BREAK_PREFIX, 8'h32, 8'h32, 8'h45, 8'h16,
                 8'h5D, 8'h1A, 8'h15, 8'h00, 8'hFF, hkt_pkg::BREAK_PREFIX,
                 hkt_pkg::BREAK_PREFIX, 8'h16, hkt_pkg::BREAK_PREFIX, 8'h00, 8'h1C,
                 hkt_pkg::BREAK_PREFIX, 8'h1C, 8'h7F, 8'h80, hkt_pkg::BREAK_PREFIX,
                 8'h5D, hkt_pkg::BREAK_PREFIX, 8'h1A, hkt_pkg::BREAK_PREFIX, 8'h32,
                 hkt_pkg::BREAK_PREFIX, 8'h45};
      foreach (code_q[i])
         send_code(code_q[i]);
      wait_for_drain();

      code_q.delete();
      window_left = 0;
      while (code_q.size() < RANDOM_ITEMS) begin
         if (window_left == 0) begin
            pool_lo     = $urandom_range(0, key_codes.size() - 1);
            pool_len    = $urandom_range(3, 12);
            window_left = 40;
         end
         window_left--;
         k    = key_codes[(pool_lo + $urandom_range(0, pool_len - 1)) % key_codes.size()];
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            code_q.push_back(k);
         end else if (pick < 82) begin
            code_q.push_back(hkt_pkg::BREAK_PREFIX);
            code_q.push_back(k);
         end else if (pick < 92) begin
            code_q.push_back(8'($urandom_range(0, 255)));
         end else if (pick < 96) begin
            code_q.push_back(hkt_pkg::BREAK_PREFIX);
            code_q.push_back(8'($urandom_range(0, 255)));
         end else begin
            code_q.push_back(hkt_pkg::BREAK_PREFIX);
            code_q.push_back(hkt_pkg::BREAK_PREFIX);
            code_q.push_back(k);
         end
      end

      half = code_q.size() / 2;
      for (int i = 0; i < code_q.size(); i++) begin
         if (i == half)
            wait_for_drain();
         send_code(code_q[i]);
      end
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/hkt_pkg.sv
design/hkt_req_if.sv
design/hkt_rsp_if.sv
design/ps2_held_key_tracker_unit.sv
verif/ps2_held_key_tracker_checker.sv
verif/ps2_held_key_tracker_unit_tb.sv
